>>> hdl/tdf_pkg.sv
// Shared constants and controller/datapath link types for the trial division factorizer.
// No dependencies; imported by tdf_ctrl, tdf_dp and trial_division_factorizer.
package tdf_pkg;

    localparam int NUMBER_BITS_DEF = 32;
    localparam int FIELD_W         = 32;
    localparam int MAX_RESULTS     = 31;
    localparam int COUNT_W         = $clog2(MAX_RESULTS + 1);

    typedef logic [FIELD_W-1:0] t_field;

    // Controller to datapath
    typedef struct packed {
        logic load;         // capture a new number, divisor back to 2
        logic div_start;    // start rest / divisor
        logic factor;       // emit (rest, divisor), replace rest by the quotient
        logic next_div;     // divisor + 1, square updated
        logic emit_final;   // emit (rest, rest) as the closing beat
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic rest_lt2;     // remaining value is 0 or 1
        logic sq_le_rest;   // divisor squared <= remaining value
        logic div_done;     // divider idle, quotient and remainder valid
        logic rem_zero;     // divisor divides the remaining value
        logic quot_lt2;     // quotient is 0 or 1
        logic count_last;   // next result reaches the result limit
        logic out_busy;     // output register still holds a beat
    } t_status;

endpackage

>>> hdl/tdf_dp.sv
// Datapath of the trial division factorizer: remaining value, divisor and its square,
// a bit-serial restoring divider, result counter and the output register. Uses tdf_pkg.
module tdf_dp #(
    parameter int NUMBER_BITS = tdf_pkg::NUMBER_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tdf_pkg::t_cmd                 i_cmd,
    output tdf_pkg::t_status              o_status,
    input  logic [NUMBER_BITS-1:0]        i_number,
    output logic                          o_tvalid,
    input  logic                          i_tready,
    output tdf_pkg::t_field               o_dividend,
    output tdf_pkg::t_field               o_prime,
    output logic                          o_last
);
    import tdf_pkg::*;

    localparam int NB     = NUMBER_BITS;
    localparam int SQ_W   = 2 * NB;
    localparam int STEP_W = $clog2(NB + 1);

    logic [NB-1:0]      r_rest;
    logic [NB-1:0]      r_div;
    logic [SQ_W-1:0]    r_sq;
    logic [COUNT_W-1:0] r_count;

    logic [NB-1:0]      r_rem;
    logic [NB-1:0]      r_quo;
    logic [STEP_W-1:0]  r_steps;
    logic               r_div_busy;

    logic               r_out_valid;
    t_field             r_out_dividend;
    t_field             r_out_prime;
    logic               r_out_last;

    logic [NB:0]        n_trial;
    logic               n_fits;
    logic [NB:0]        n_diff;

    // one restoring division step
    always_comb begin
        n_trial = {r_rem, r_quo[NB-1]};
        n_diff  = n_trial - {1'b0, r_div};
        n_fits  = (n_trial >= {1'b0, r_div});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_busy <= 1'b0;
            r_steps    <= '0;
            r_count    <= '0;
        end else begin
            if (i_cmd.load) begin
                r_rest  <= i_number;
                r_div   <= NB'(2);
                r_sq    <= SQ_W'(4);
                r_count <= '0;
            end
            if (i_cmd.div_start) begin
                r_rem      <= '0;
                r_quo      <= r_rest;
                r_steps    <= STEP_W'(NB);
                r_div_busy <= 1'b1;
            end else if (r_div_busy) begin
                r_rem   <= n_fits ? n_diff[NB-1:0] : n_trial[NB-1:0];
                r_quo   <= {r_quo[NB-2:0], n_fits};
                r_steps <= r_steps - STEP_W'(1);
                if (r_steps == STEP_W'(1)) begin
                    r_div_busy <= 1'b0;
                end
            end
            if (i_cmd.factor) begin
                r_rest  <= r_quo;
                r_count <= r_count + COUNT_W'(1);
            end
            if (i_cmd.next_div) begin
                r_div <= r_div + NB'(1);
                r_sq  <= r_sq + SQ_W'({r_div, 1'b1});
            end
        end
    end

    // output register: the search keeps running while a beat waits here
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.factor || i_cmd.emit_final) begin
                r_out_valid <= 1'b1;
            end else if (i_tready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (i_cmd.factor) begin
            r_out_dividend <= t_field'(r_rest);
            r_out_prime    <= t_field'(r_div);
            r_out_last     <= (r_quo < NB'(2)) ||
                              (r_count == COUNT_W'(MAX_RESULTS - 1));
        end else if (i_cmd.emit_final) begin
            r_out_dividend <= t_field'(r_rest);
            r_out_prime    <= t_field'(r_rest);
            r_out_last     <= 1'b1;
        end
    end

    always_comb begin
        o_status.rest_lt2   = (r_rest < NB'(2));
        o_status.sq_le_rest = (r_sq <= SQ_W'(r_rest));
        o_status.div_done   = !r_div_busy;
        o_status.rem_zero   = (r_rem == '0);
        o_status.quot_lt2   = (r_quo < NB'(2));
        o_status.count_last = (r_count == COUNT_W'(MAX_RESULTS - 1));
        o_status.out_busy   = r_out_valid;
    end

    assign o_tvalid   = r_out_valid;
    assign o_dividend = r_out_dividend;
    assign o_prime    = r_out_prime;
    assign o_last     = r_out_last;

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.factor || i_cmd.emit_final) |-> (!r_out_valid || i_tready))
        else $error("result written over a pending beat");

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_start |-> !r_div_busy)
        else $error("divider restarted while busy");

    a_rest_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.factor && !i_cmd.load) |=> (r_rest < $past(r_rest)))
        else $error("remaining value did not shrink after a factor");

endmodule

>>> hdl/tdf_ctrl.sv
// Controller of the trial division factorizer: sequences load, divisor trials and result
// emission through command and status structs from tdf_pkg.
module tdf_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_tvalid,
    output logic              o_tready,
    input  tdf_pkg::t_status  i_status,
    output tdf_pkg::t_cmd     o_cmd
);
    import tdf_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_CHECK,
        S_DIVIDE,
        S_DECIDE,
        S_FINAL
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_tready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_START;
                end
            end
            S_START: begin
                n_state = i_status.rest_lt2 ? S_IDLE : S_CHECK;
            end
            S_CHECK: begin
                if (i_status.sq_le_rest) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIVIDE;
                end else begin
                    n_state = S_FINAL;
                end
            end
            S_DIVIDE: begin
                if (i_status.div_done) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (!i_status.rem_zero) begin
                    o_cmd.next_div = 1'b1;
                    n_state        = S_CHECK;
                end else if (!i_status.out_busy) begin
                    o_cmd.factor = 1'b1;
                    // stop when the quotient leaves nothing or the result limit is hit
                    if (i_status.quot_lt2 || i_status.count_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_CHECK;
                    end
                end
            end
            S_FINAL: begin
                if (!i_status.out_busy) begin
                    o_cmd.emit_final = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.load, o_cmd.div_start, o_cmd.factor, o_cmd.next_div,
                  o_cmd.emit_final}))
        else $error("more than one command issued");

    a_emit_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.factor || o_cmd.emit_final) |-> !i_status.out_busy)
        else $error("emit issued while output busy");

    a_decide_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DECIDE) |-> i_status.div_done)
        else $error("decision taken before division finished");

endmodule

>>> hdl/trial_division_factorizer.sv
// Trial division factorizer: one number in, one beat per prime factor out (none for 0 or 1), last marked.
// Each divisor trial runs the bit-serial divider, one quotient bit a cycle; a number
// takes about one division per divisor trial plus one per factor found.
// One number is in work at a time.
// A finished beat waits in the output register while the search goes on.
// Reset: synchronous, active low; clears the controller and output valid, no clearing pass.
module trial_division_factorizer #(
    parameter int NUMBER_BITS = tdf_pkg::NUMBER_BITS_DEF,
    localparam int IN_W = ((NUMBER_BITS + 7) / 8) * 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [IN_W-1:0]                s_axis_tdata,   // [NUMBER_BITS-1:0] number
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [2*tdf_pkg::FIELD_W-1:0]  m_axis_tdata,   // prime_factor, dividend_before
    output logic                           m_axis_tlast
);
    import tdf_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;
    t_field  w_dividend;
    t_field  w_prime;

    tdf_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tvalid (s_axis_tvalid),
        .o_tready (s_axis_tready),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    tdf_dp #(
        .NUMBER_BITS (NUMBER_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_status   (w_status),
        .i_number   (s_axis_tdata[NUMBER_BITS-1:0]),
        .o_tvalid   (m_axis_tvalid),
        .i_tready   (m_axis_tready),
        .o_dividend (w_dividend),
        .o_prime    (w_prime),
        .o_last     (m_axis_tlast)
    );

    assign m_axis_tdata = {w_prime, w_dividend};

endmodule
